/* rtl/adeg_pkg.sv */
// Shared types and constants for the attack-decay envelope gain block.
// Used by adeg_step_unit and attack_decay_envelope_gain_core; no dependencies.
package adeg_pkg;

    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int COUNT_BITS_DEF     = 20;
    localparam int GAIN_FRAC_BITS_DEF = 16;

    localparam int ATTACK_RESET = 480;
    localparam int DECAY_RESET  = 480;

    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ATTACK = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DECAY  = 2'd1;

    localparam logic [2:0] SEG_ATTACK_LO = 3'd0;
    localparam logic [2:0] SEG_ATTACK_HI = 3'd1;
    localparam logic [2:0] SEG_SUSTAIN   = 3'd2;
    localparam logic [2:0] SEG_DECAY_HI  = 3'd3;
    localparam logic [2:0] SEG_DECAY_LO  = 3'd4;

    typedef enum logic {
        STEP_DIV  = 1'b0,
        STEP_SQRT = 1'b1
    } step_mode_t;

    typedef enum logic [1:0] {
        KIND_UNITY  = 2'd0,
        KIND_ZERO   = 2'd1,
        KIND_SQUARE = 2'd2,
        KIND_ROOT   = 2'd3
    } gain_kind_t;

endpackage

/* rtl/adeg_step_unit.sv */
// Shared compare/subtract unit: one restoring divide step or one root digit step.
// Depends on adeg_pkg.
module adeg_step_unit #(
    parameter int REM_W  = 24,
    parameter int DIV_W  = 20,
    parameter int ROOT_W = 17
) (
    input  adeg_pkg::step_mode_t mode,
    input  logic [REM_W-1:0]     rem_in,
    input  logic [1:0]           pair,
    input  logic [ROOT_W-1:0]    root_in,
    input  logic [DIV_W-1:0]     divisor,
    output logic [REM_W-1:0]     rem_out,
    output logic                 bit_out
);

    logic [REM_W-1:0] shifted;
    logic [REM_W-1:0] trial;
    logic [REM_W:0]   diff;

    always_comb
    begin
        unique case (mode)
            adeg_pkg::STEP_DIV:
            begin
                shifted = {rem_in[REM_W-2:0], 1'b0};
                trial   = REM_W'(divisor);
            end
            adeg_pkg::STEP_SQRT:
            begin
                shifted = {rem_in[REM_W-3:0], pair};
                trial   = REM_W'({root_in, 2'b01});
            end
            default:
            begin
                shifted = '0;
                trial   = '0;
            end
        endcase
        diff    = {1'b0, shifted} - {1'b0, trial};
        bit_out = ~diff[REM_W];
        rem_out = bit_out ? diff[REM_W-1:0] : shifted;
    end

endmodule

/* rtl/attack_decay_envelope_gain_core.sv */
// Top level of the attack-decay envelope gain block: sequencer, note state, multiplier.
// Depends on adeg_pkg and adeg_step_unit.
//
//  channel | signals                                   | direction
//  in      | in_valid in_ready sample_in note_start note_length | sink
//  out     | out_valid out_ready sample_out segment    | source
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data    | sink
//
// Each input transfer at unity or zero gain skips the divide; a square-law
// segment uses the one-bit-per-cycle ratio divide and a root-law segment adds
// the two-bits-per-cycle square root after it.
// in_ready is high only while the sequencer is idle; a result waiting on
// out_ready does not block the next input transfer, only the next result.
// rst_n clears control and note state; cfg_ready is always high.
module attack_decay_envelope_gain_core #(
    parameter int SAMPLE_BITS    = adeg_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS     = adeg_pkg::COUNT_BITS_DEF,
    parameter int GAIN_FRAC_BITS = adeg_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [SAMPLE_BITS-1:0]       sample_in,
    input  logic                                note_start,
    input  logic [COUNT_BITS-1:0]               note_length,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [SAMPLE_BITS-1:0]       sample_out,
    output logic [2:0]                          segment,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [adeg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COUNT_BITS-1:0]               cfg_data
);

    localparam int S       = SAMPLE_BITS;
    localparam int C       = COUNT_BITS;
    localparam int F       = GAIN_FRAC_BITS;
    localparam int REM_W   = (C + 1 > F + 4) ? C + 1 : F + 4;
    localparam int MUL_A_W = (S > F + 1) ? S : F + 1;
    localparam int PROD_W  = MUL_A_W + F + 1;
    localparam int CNT_W   = $clog2(F + 1) + 1;

    localparam logic [F:0]   UNITY_G   = {1'b1, {F{1'b0}}};
    localparam logic [F+1:0] ROOT_BIAS = {2'b01, {(F-1){1'b0}}, 1'b1};

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_NOTE = 10'b0000000010,
        ST_SEL  = 10'b0000000100,
        ST_DIV  = 10'b0000001000,
        ST_PREP = 10'b0000010000,
        ST_SQRT = 10'b0000100000,
        ST_SQ   = 10'b0001000000,
        ST_GAIN = 10'b0010000000,
        ST_MUL  = 10'b0100000000,
        ST_RND  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [C-1:0] attack_reg, attack_next;
    logic [C-1:0] decay_reg, decay_next;
    logic [C-1:0] pos_reg, pos_next;
    logic [C-1:0] ha_reg, ha_next;
    logic [C-1:0] ha2_reg, ha2_next;
    logic [C-1:0] hd_reg, hd_next;
    logic [C-1:0] ds_reg, ds_next;
    logic [C-1:0] hde_reg, hde_next;
    logic [C-1:0] total_reg, total_next;
    logic         out_valid_reg, out_valid_next;

    logic [S-1:0]         x_reg, x_next;
    logic                 start_reg, start_next;
    logic [C-1:0]         len_reg, len_next;
    logic                 neg_reg, neg_next;
    logic [S-1:0]         mag_reg, mag_next;
    logic [2:0]           seg_reg, seg_next;
    adeg_pkg::gain_kind_t kind_reg, kind_next;
    logic                 comp_reg, comp_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [F-1:0]         q_reg, q_next;
    logic [C-1:0]         divisor_reg, divisor_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [2*F+1:0]       rad_reg, rad_next;
    logic [F:0]           root_reg, root_next;
    logic [F:0]           rp_reg, rp_next;
    logic [F:0]           gain_reg, gain_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [S-1:0]         out_sample_reg, out_sample_next;
    logic [2:0]           out_seg_reg, out_seg_next;

    adeg_pkg::step_mode_t step_mode;
    logic [REM_W-1:0]     step_rem;
    logic                 step_bit;

    logic [C:0]          att2, dec2, lenx, ma, md;
    logic [C:0]          md_up;
    logic [C-1:0]        k_val;
    logic [MUL_A_W-1:0]  mul_a;
    logic [F:0]          mul_b;
    logic [PROD_W-1:0]   mul_p;
    logic [PROD_W:0]     sq_sum;
    logic [F+1:0]        root_sum;
    logic [PROD_W:0]     rnd_sum;
    logic [PROD_W-F:0]   rnd_mag;
    logic [S-1:0]        lim;
    logic [S-1:0]        clamped;

    adeg_step_unit #(
        .REM_W  (REM_W),
        .DIV_W  (C),
        .ROOT_W (F + 1)
    ) u_step (
        .mode    (step_mode),
        .rem_in  (rem_reg),
        .pair    (rad_reg[2*F+1:2*F]),
        .root_in (root_reg),
        .divisor (divisor_reg),
        .rem_out (step_rem),
        .bit_out (step_bit)
    );

    assign step_mode = (state_reg == ST_SQRT) ? adeg_pkg::STEP_SQRT : adeg_pkg::STEP_DIV;

    assign mul_a = (state_reg == ST_SQ) ? MUL_A_W'(rp_reg) : MUL_A_W'(mag_reg);
    assign mul_b = (state_reg == ST_SQ) ? rp_reg : gain_reg;
    assign mul_p = mul_a * mul_b;

    assign att2  = {attack_reg, 1'b0};
    assign dec2  = {decay_reg, 1'b0};
    assign lenx  = {1'b0, len_reg};
    assign ma    = (att2 > lenx) ? lenx : att2;
    assign md    = (dec2 > lenx) ? lenx : dec2;
    assign md_up = md + (C+1)'(1);
    assign k_val = pos_reg - hde_reg;

    assign sq_sum   = {1'b0, prod_reg} + (PROD_W+1)'(UNITY_G);
    assign root_sum = {1'b0, root_reg} + ROOT_BIAS;
    assign rnd_sum  = {1'b0, prod_reg} + (PROD_W+1)'(UNITY_G >> 1);
    assign rnd_mag  = rnd_sum[PROD_W:F];
    assign lim      = neg_reg ? {1'b1, {(S-1){1'b0}}} : {1'b0, {(S-1){1'b1}}};
    assign clamped  = (rnd_mag > (PROD_W-F+1)'(lim)) ? lim : rnd_mag[S-1:0];

    always_comb
    begin
        state_next      = state_reg;
        attack_next     = attack_reg;
        decay_next      = decay_reg;
        pos_next        = pos_reg;
        ha_next         = ha_reg;
        ha2_next        = ha2_reg;
        hd_next         = hd_reg;
        ds_next         = ds_reg;
        hde_next        = hde_reg;
        total_next      = total_reg;
        out_valid_next  = out_valid_reg;
        x_next          = x_reg;
        start_next      = start_reg;
        len_next        = len_reg;
        neg_next        = neg_reg;
        mag_next        = mag_reg;
        seg_next        = seg_reg;
        kind_next       = kind_reg;
        comp_next       = comp_reg;
        rem_next        = rem_reg;
        q_next          = q_reg;
        divisor_next    = divisor_reg;
        cnt_next        = cnt_reg;
        rad_next        = rad_reg;
        root_next       = root_reg;
        rp_next         = rp_reg;
        gain_next       = gain_reg;
        prod_next       = prod_reg;
        out_sample_next = out_sample_reg;
        out_seg_next    = out_seg_reg;

        if (cfg_valid)
        begin
            if (cfg_index == adeg_pkg::REG_ATTACK)
            begin
                attack_next = cfg_data;
            end
            else if (cfg_index == adeg_pkg::REG_DECAY)
            begin
                decay_next = cfg_data;
            end
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    x_next     = sample_in;
                    start_next = note_start;
                    len_next   = note_length;
                    state_next = ST_NOTE;
                end
            end
            ST_NOTE:
            begin
                neg_next = x_reg[S-1];
                mag_next = x_reg[S-1] ? (~x_reg + S'(1)) : x_reg;
                if (start_reg)
                begin
                    total_next = len_reg;
                    ha_next    = C'(ma[C-1:2]);
                    ha2_next   = C'({ma[C-1:2], 1'b0});
                    hd_next    = C'(md[C-1:2]);
                    ds_next    = len_reg - md_up[C:1];
                    hde_next   = len_reg - md_up[C:1] + C'(md[C-1:2]);
                    pos_next   = '0;
                end
                state_next = ST_SEL;
            end
            ST_SEL:
            begin
                comp_next = 1'b0;
                cnt_next  = '0;
                q_next    = '0;
                priority if (pos_reg < ha_reg)
                begin
                    seg_next     = adeg_pkg::SEG_ATTACK_LO;
                    kind_next    = adeg_pkg::KIND_SQUARE;
                    rem_next     = REM_W'(pos_reg);
                    divisor_next = ha_reg;
                end
                else if (pos_reg < ha2_reg)
                begin
                    seg_next     = adeg_pkg::SEG_ATTACK_HI;
                    kind_next    = adeg_pkg::KIND_ROOT;
                    rem_next     = REM_W'(pos_reg - ha_reg);
                    divisor_next = ha_reg;
                end
                else if (pos_reg < ds_reg)
                begin
                    seg_next  = adeg_pkg::SEG_SUSTAIN;
                    kind_next = adeg_pkg::KIND_UNITY;
                end
                else if (pos_reg < hde_reg)
                begin
                    seg_next     = adeg_pkg::SEG_DECAY_HI;
                    kind_next    = adeg_pkg::KIND_ROOT;
                    comp_next    = 1'b1;
                    rem_next     = REM_W'(pos_reg - ds_reg);
                    divisor_next = hd_reg;
                end
                else
                begin
                    seg_next     = adeg_pkg::SEG_DECAY_LO;
                    comp_next    = 1'b1;
                    rem_next     = REM_W'(k_val);
                    divisor_next = hd_reg;
                    if (k_val >= hd_reg || pos_reg >= total_reg)
                    begin
                        kind_next = adeg_pkg::KIND_ZERO;
                    end
                    else
                    begin
                        kind_next = adeg_pkg::KIND_SQUARE;
                    end
                end
                state_next = ST_DIV;
                if (kind_next == adeg_pkg::KIND_UNITY)
                begin
                    gain_next  = UNITY_G;
                    state_next = ST_MUL;
                end
                else if (kind_next == adeg_pkg::KIND_ZERO)
                begin
                    gain_next  = '0;
                    state_next = ST_MUL;
                end
            end
            ST_DIV:
            begin
                rem_next = step_rem;
                q_next   = {q_reg[F-2:0], step_bit};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(F - 1))
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                rp_next   = comp_reg ? (UNITY_G - {1'b0, q_reg}) : {1'b0, q_reg};
                rad_next  = {1'b0, rp_next, {F{1'b0}}};
                rem_next  = '0;
                root_next = '0;
                cnt_next  = '0;
                state_next = (kind_reg == adeg_pkg::KIND_ROOT) ? ST_SQRT : ST_SQ;
            end
            ST_SQRT:
            begin
                rem_next  = step_rem;
                root_next = {root_reg[F-1:0], step_bit};
                rad_next  = {rad_reg[2*F-1:0], 2'b00};
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(F))
                begin
                    state_next = ST_GAIN;
                end
            end
            ST_SQ:
            begin
                prod_next  = mul_p;
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                if (kind_reg == adeg_pkg::KIND_ROOT)
                begin
                    gain_next = root_sum[F+1:1];
                end
                else
                begin
                    gain_next = sq_sum[2*F+1:F+1];
                end
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = mul_p;
                state_next = ST_RND;
            end
            ST_RND:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_sample_next = neg_reg ? (~clamped + S'(1)) : clamped;
                    out_seg_next    = seg_reg;
                    out_valid_next  = 1'b1;
                    if (pos_reg != {C{1'b1}})
                    begin
                        pos_next = pos_reg + C'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            attack_reg    <= C'(adeg_pkg::ATTACK_RESET);
            decay_reg     <= C'(adeg_pkg::DECAY_RESET);
            pos_reg       <= '0;
            ha_reg        <= '0;
            ha2_reg       <= '0;
            hd_reg        <= '0;
            ds_reg        <= '0;
            hde_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            attack_reg    <= attack_next;
            decay_reg     <= decay_next;
            pos_reg       <= pos_next;
            ha_reg        <= ha_next;
            ha2_reg       <= ha2_next;
            hd_reg        <= hd_next;
            ds_reg        <= ds_next;
            hde_reg       <= hde_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        start_reg      <= start_next;
        len_reg        <= len_next;
        neg_reg        <= neg_next;
        mag_reg        <= mag_next;
        seg_reg        <= seg_next;
        kind_reg       <= kind_next;
        comp_reg       <= comp_next;
        rem_reg        <= rem_next;
        q_reg          <= q_next;
        divisor_reg    <= divisor_next;
        cnt_reg        <= cnt_next;
        rad_reg        <= rad_next;
        root_reg       <= root_next;
        rp_reg         <= rp_next;
        gain_reg       <= gain_next;
        prod_reg       <= prod_next;
        out_sample_reg <= out_sample_next;
        out_seg_reg    <= out_seg_next;
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign sample_out = out_sample_reg;
    assign segment    = out_seg_reg;

    // result only appears from the rounding step
    a_out_from_rnd: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RND))
        else $error("result raised outside rounding step");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg < CNT_W'(F)))
        else $error("divide step count out of range");

    a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (gain_reg <= UNITY_G))
        else $error("gain above unity");

    a_sq_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQ) |-> (kind_reg == adeg_pkg::KIND_SQUARE))
        else $error("square step on non-square segment");

    a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_seg_reg <= adeg_pkg::SEG_DECAY_LO))
        else $error("segment code out of range");

endmodule
